// ===== hdl/cwnms_pkg.sv =====
// Shared types and register codes for the class-wise box NMS unit.
// No dependencies.
package cwnms_pkg;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] right;
    logic signed [15:0] bottom;
  } box_t;

  typedef struct packed {
    logic [15:0] score;
    logic [7:0]  cls;
  } score_class_t;

  localparam logic [1:0] REG_SCORE_THR   = 2'd0;
  localparam logic [1:0] REG_OVERLAP_THR = 2'd1;
  localparam logic [1:0] REG_CAND_LIMIT  = 2'd2;

  localparam logic [15:0] SCORE_THR_RESET   = 16'd16384;
  localparam logic [15:0] OVERLAP_THR_RESET = 16'd29491;
  localparam logic [6:0]  CAND_LIMIT_RESET  = 7'd64;
  localparam logic [6:0]  ARRIVAL_MAX       = 7'd127;

endpackage

// ===== hdl/cwnms_overlap.sv =====
// Four-stage pipelined overlap test: inter*65536 >= thr*union, union > 0.
// Depends on cwnms_pkg.
module cwnms_overlap
  import cwnms_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  box_t        box_a,
  input  box_t        box_b,
  input  logic [15:0] thr,
  output logic        done,
  output logic        hit
);
  logic [3:0] vld;
  logic signed [16:0] dw, dh, aw, ah, bw, bh;
  logic ovl;
  logic signed [33:0] inter, area_a, area_b;
  logic signed [35:0] uni;
  logic signed [33:0] inter3;

  logic signed [15:0] il, it, ir, ib;
  always_comb begin
    il = (box_a.left > box_b.left) ? box_a.left : box_b.left;
    it = (box_a.top > box_b.top) ? box_a.top : box_b.top;
    ir = (box_a.right < box_b.right) ? box_a.right : box_b.right;
    ib = (box_a.bottom < box_b.bottom) ? box_a.bottom : box_b.bottom;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], go};
    end
  end

  logic signed [52:0] lhs, rhs;
  always_comb begin
    lhs = {{19{inter3[33]}}, inter3} <<< 16;
    rhs = $signed({1'b0, thr}) * uni;
  end

  always_ff @(posedge clk) begin
    dw     <= 17'(ir) - 17'(il);
    dh     <= 17'(ib) - 17'(it);
    ovl    <= (il <= ir) && (it <= ib);
    aw     <= 17'(box_a.right) - 17'(box_a.left);
    ah     <= 17'(box_a.bottom) - 17'(box_a.top);
    bw     <= 17'(box_b.right) - 17'(box_b.left);
    bh     <= 17'(box_b.bottom) - 17'(box_b.top);
    inter  <= ovl ? dw * dh : '0;
    area_a <= aw * ah;
    area_b <= bw * bh;
    uni    <= 36'(area_a) + 36'(area_b) - 36'(inter);
    inter3 <= inter;
    hit    <= (uni > 0) && (lhs >= rhs);
  end

  assign done = vld[3];
endmodule

// ===== hdl/class_wise_box_nms_unit.sv =====
// Class-wise greedy box NMS: top level with APB registers, candidate
// memories and the selection/suppression sequencer. Depends on cwnms_pkg, cwnms_overlap.
//
// Candidates are taken one per cycle while busy is low; each that meets the
// score threshold, the candidate limit and the memory size is written to the
// box and score/class memories at once, with its processed and suppressed
// flags cleared. The item with frame_end raises busy until every result of the
// frame has been sent. The sequencer then picks the next candidate in order
// (class ascending, score descending, arrival) with a scan of the score/class
// memory, and for each kept box scans the memory again, sending each unprocessed,
// unsuppressed candidate of the same class through the overlap pipeline.
// Results come on one-cycle result_strobe pulses and cannot be stalled.
module class_wise_box_nms_unit
  import cwnms_pkg::*;
#(
  parameter int MAX_DETS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] box_left,
  input  logic signed [15:0] box_top,
  input  logic signed [15:0] box_right,
  input  logic signed [15:0] box_bottom,
  input  logic        [15:0] score,
  input  logic        [7:0]  class_index,
  input  logic               frame_end,
  output logic               result_strobe,
  output logic signed [15:0] kept_left,
  output logic signed [15:0] kept_top,
  output logic signed [15:0] kept_right,
  output logic signed [15:0] kept_bottom,
  output logic        [15:0] kept_score,
  output logic        [7:0]  kept_class,
  output logic               result_valid,
  output logic               result_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic        [3:0]  paddr,
  input  logic        [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready
);
  localparam int AW = (MAX_DETS > 1) ? $clog2(MAX_DETS) : 1;
  localparam int CW = $clog2(MAX_DETS + 1);
  localparam logic [6:0] MAX7 = 7'(MAX_DETS);
  localparam logic [CW-1:0] MAXC = CW'(MAX_DETS);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_SEL_RD  = 9'b000000010,
    S_SEL_EV  = 9'b000000100,
    S_FETCH   = 9'b000001000,
    S_FETCH_W = 9'b000010000,
    S_SUP_RD  = 9'b000100000,
    S_SUP_EV  = 9'b001000000,
    S_SUP_WT  = 9'b010000000,
    S_FINISH  = 9'b100000000
  } state_t;

  typedef struct packed {
    logic         processed;
    logic         suppressed;
    score_class_t sc;
  } entry_t;

  state_t state;
  logic [15:0] score_thr, overlap_thr;
  logic [6:0]  cand_limit;
  logic [6:0]  arrival_count;
  logic [CW-1:0] stored_count;
  logic [CW-1:0] scan;
  logic found;
  logic [23:0] best_key;
  logic [AW-1:0] best_idx;
  score_class_t best_sc;
  box_t best_box;
  logic pend_valid;
  box_t pend_box;
  score_class_t pend_sc;

  // configuration port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  always_ff @(posedge clk) begin
    if (rst) begin
      score_thr   <= SCORE_THR_RESET;
      overlap_thr <= OVERLAP_THR_RESET;
      cand_limit  <= CAND_LIMIT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_SCORE_THR:   score_thr <= pwdata[15:0];
        REG_OVERLAP_THR: overlap_thr <= pwdata[15:0];
        REG_CAND_LIMIT:  cand_limit <= pwdata[6:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (paddr[3:2])
      REG_SCORE_THR:   prdata = {16'd0, score_thr};
      REG_OVERLAP_THR: prdata = {16'd0, overlap_thr};
      REG_CAND_LIMIT:  prdata = {25'd0, cand_limit};
      default:         prdata = '0;
    endcase
  end

  // candidate memories
  box_t box_mem [MAX_DETS];
  entry_t sc_mem [MAX_DETS];
  box_t box_q;
  entry_t sc_q;
  logic [AW-1:0] rd_addr;
  logic accept, store_en;
  logic [6:0] eff_limit;
  logic sc_we;
  logic [AW-1:0] sc_waddr;
  entry_t sc_wdata;
  logic ov_go, ov_done, ov_hit;

  assign busy = (state != S_IDLE);
  assign accept = start && !busy;
  assign eff_limit = (cand_limit < MAX7) ? cand_limit : MAX7;
  assign store_en = accept && (arrival_count < eff_limit) &&
                    (stored_count < MAXC) && (score >= score_thr);

  always_comb begin
    if (state == S_FETCH) rd_addr = best_idx;
    else rd_addr = scan[AW-1:0];
  end

  // flags are read-modify-written from the entry read the cycle before
  always_comb begin
    sc_we    = 1'b0;
    sc_waddr = stored_count[AW-1:0];
    sc_wdata = {2'b00, score, class_index};
    if (store_en) begin
      sc_we = 1'b1;
    end else if (state == S_FETCH_W) begin
      sc_we    = 1'b1;
      sc_waddr = best_idx;
      sc_wdata = sc_q;
      sc_wdata.processed = 1'b1;
    end else if ((state == S_SUP_WT) && ov_done && ov_hit) begin
      sc_we    = 1'b1;
      sc_waddr = scan[AW-1:0];
      sc_wdata = sc_q;
      sc_wdata.suppressed = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (store_en) begin
      box_mem[stored_count[AW-1:0]] <= '{box_left, box_top, box_right, box_bottom};
    end
    if (sc_we) begin
      sc_mem[sc_waddr] <= sc_wdata;
    end
    box_q <= box_mem[rd_addr];
    sc_q  <= sc_mem[rd_addr];
  end

  cwnms_overlap u_overlap (
    .clk   (clk),
    .rst   (rst),
    .go    (ov_go),
    .box_a (best_box),
    .box_b (box_q),
    .thr   (overlap_thr),
    .done  (ov_done),
    .hit   (ov_hit)
  );

  logic [23:0] cand_key;
  assign cand_key = {sc_q.sc.cls, ~sc_q.sc.score};
  assign ov_go = (state == S_SUP_EV) && !sc_q.processed && !sc_q.suppressed &&
                 (sc_q.sc.cls == best_sc.cls);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      arrival_count <= '0;
      stored_count  <= '0;
      scan          <= '0;
      found         <= 1'b0;
      pend_valid    <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (store_en) stored_count <= stored_count + 1'b1;
            if (arrival_count != ARRIVAL_MAX) arrival_count <= arrival_count + 1'b1;
            if (frame_end) begin
              scan  <= '0;
              found <= 1'b0;
              state <= S_SEL_RD;
            end
          end
        end
        S_SEL_RD: begin
          if (scan == stored_count) begin
            state <= found ? S_FETCH : S_FINISH;
          end else begin
            state <= S_SEL_EV;
          end
        end
        S_SEL_EV: begin
          if (!sc_q.processed && (!found || cand_key < best_key)) begin
            found    <= 1'b1;
            best_key <= cand_key;
            best_idx <= scan[AW-1:0];
            best_sc  <= sc_q.sc;
          end
          scan  <= scan + 1'b1;
          state <= S_SEL_RD;
        end
        S_FETCH: state <= S_FETCH_W;
        S_FETCH_W: begin
          best_box <= box_q;
          scan     <= '0;
          found    <= 1'b0;
          if (sc_q.suppressed) begin
            state <= S_SEL_RD;
          end else begin
            // flush the held result: it is not the last one
            if (pend_valid) begin
              result_strobe <= 1'b1;
              {kept_left, kept_top, kept_right, kept_bottom} <= pend_box;
              kept_score   <= pend_sc.score;
              kept_class   <= pend_sc.cls;
              result_valid <= 1'b1;
              result_last  <= 1'b0;
            end
            pend_valid <= 1'b1;
            pend_box   <= box_q;
            pend_sc    <= best_sc;
            state      <= S_SUP_RD;
          end
        end
        S_SUP_RD: begin
          if (scan == stored_count) begin
            scan  <= '0;
            state <= S_SEL_RD;
          end else begin
            state <= S_SUP_EV;
          end
        end
        S_SUP_EV: begin
          if (ov_go) begin
            state <= S_SUP_WT;
          end else begin
            scan  <= scan + 1'b1;
            state <= S_SUP_RD;
          end
        end
        S_SUP_WT: begin
          if (ov_done) begin
            scan  <= scan + 1'b1;
            state <= S_SUP_RD;
          end
        end
        S_FINISH: begin
          result_strobe <= 1'b1;
          result_last   <= 1'b1;
          result_valid  <= pend_valid;
          if (pend_valid) begin
            {kept_left, kept_top, kept_right, kept_bottom} <= pend_box;
            kept_score <= pend_sc.score;
            kept_class <= pend_sc.cls;
          end else begin
            {kept_left, kept_top, kept_right, kept_bottom} <= '0;
            kept_score <= '0;
            kept_class <= '0;
          end
          pend_valid    <= 1'b0;
          arrival_count <= '0;
          stored_count  <= '0;
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(busy)) else $error("result outside a frame");
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !result_valid) |-> result_last) else $error("empty result not last");
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    stored_count <= MAXC) else $error("stored count overflow");
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (busy && !$past(busy)) |-> !pend_valid)
    else $error("frame state not cleared");

endmodule
